/* design/trdt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the triangle rasterizer with depth test.
// No dependencies; used by design/triangle_raster_depth_test.sv.
package trdt_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDATA,
    ST_BOX,
    ST_MUL,
    ST_DIV,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Operation codes carried in s_tuser.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam int COORD_W    = 20;
  localparam int ZIN_W      = 18;
  localparam int ID_W       = 16;
  localparam int PADDR_IN_W = 14;
  localparam int DEPTH_W    = 17;
  localparam int COUNT_W    = 15;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 48;

  localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = 17'h1FFFF;
  localparam logic signed [63:0] DEPTH_ONE   = 64'sd65536;

  // Setup multiplier: bits of the multiplier operand and the job codes
  // that close an accumulation group.
  localparam int MUL_BITS = 48;
  localparam int DIV_BITS = 64;
  localparam logic [4:0] JOB_AREA = 5'd1;
  localparam logic [4:0] JOB_W0   = 5'd3;
  localparam logic [4:0] JOB_W1   = 5'd5;
  localparam logic [4:0] JOB_W2   = 5'd7;
  localparam logic [4:0] JOB_NUM  = 5'd10;
  localparam logic [4:0] JOB_NX   = 5'd13;
  localparam logic [4:0] JOB_NY   = 5'd16;

  // Divider jobs: start depth numerator, column step, row step.
  localparam logic [1:0] DJ_START = 2'd0;
  localparam logic [1:0] DJ_STEPX = 2'd1;
  localparam logic [1:0] DJ_STEPY = 2'd2;

endpackage

/* design/triangle_raster_depth_test.sv */
`timescale 1ns / 1ps
// Triangle rasterizer with depth test over one depth/id store.
// Depends on design/trdt_pkg.sv.

// Depth and triangle id share one synchronous RAM of MAX_WIDTH*MAX_HEIGHT words
// (one write and one registered read per cycle). After reset the block sweeps
// every word of the RAM to empty with s_tready low; a clear command takes the
// same sweep. A read passes through the READ and RDATA states to DONE. A draw
// first sets up (the bounding box, 17 products on a shift-and-add multiplier,
// three quotients on a restoring divider), then walks each pixel of the clipped
// bounding box and drains; the pixel walk is bound by the RAM port, one
// read-compare-write per pixel, with edge values and depth stepped
// incrementally as quotient and remainder. Triangles culled by depth or by an
// empty clipped box finish straight from the bounding-box state; those of
// nonpositive area finish after the area product. A finished result waits in
// the m_tdata register while the next beat is accepted.
module triangle_raster_depth_test #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, tri_index, pixel_addr
  input  logic [trdt_pkg::IN_DATA_W-1:0] s_tdata,
  // mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // depth_value, triangle_id, pixels_updated
  output logic [trdt_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int DW    = trdt_pkg::DEPTH_W + INDEX_BITS;

  trdt_pkg::state_t state, state_next;

  // Configuration.
  logic [7:0] screen_width, screen_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 8'd128;
      screen_height <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        trdt_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[7:0];
        trdt_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      trdt_pkg::REG_SCREEN_WIDTH:  prdata = {24'd0, screen_width};
      trdt_pkg::REG_SCREEN_HEIGHT: prdata = {24'd0, screen_height};
      default:                     prdata = 32'd0;
    endcase
  end

  // Input capture.
  logic s_acc;
  logic signed [19:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic signed [17:0] vz0, vz1, vz2;
  logic [INDEX_BITS-1:0] tid;
  logic [13:0] pix_addr;
  logic [31:0] tid32;

  assign s_tready = (state == trdt_pkg::ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign tid32    = 32'(s_tdata[189:174]);

  // Differences and box bounds in 22-bit signed; the clamped screen size is 12-bit unsigned.
  logic signed [21:0] ex0, ey0, ex1, ey1, ex2, ey2;
  logic signed [21:0] ea0, eb0, ea1, eb1, ea2, eb2;
  logic signed [21:0] mnx, mxx, mny, mxy, bl, br, bt, bb, br15, bb15, wlim, hlim;
  logic [11:0] weff, heff;
  logic box_empty, zcull;
  logic [XW-1:0] px0, px1, px;
  logic [YW-1:0] py0, py1, py;
  logic signed [21:0] cx0, cy0;

  function automatic logic z_out(input logic signed [17:0] z);
    return z[17] || (z > 18'sd65536);
  endfunction

  always_comb begin
    ex0 = 22'(vx0); ey0 = 22'(vy0);
    ex1 = 22'(vx1); ey1 = 22'(vy1);
    ex2 = 22'(vx2); ey2 = 22'(vy2);
    ea0 = ey2 - ey1; eb0 = ex2 - ex1;
    ea1 = ey0 - ey2; eb1 = ex0 - ex2;
    ea2 = ey1 - ey0; eb2 = ex1 - ex0;
    mnx = (ex0 < ex1) ? ex0 : ex1;
    mnx = (mnx < ex2) ? mnx : ex2;
    mxx = (ex0 > ex1) ? ex0 : ex1;
    mxx = (mxx > ex2) ? mxx : ex2;
    mny = (ey0 < ey1) ? ey0 : ey1;
    mny = (mny < ey2) ? mny : ey2;
    mxy = (ey0 > ey1) ? ey0 : ey1;
    mxy = (mxy > ey2) ? mxy : ey2;
    weff = ({4'd0, screen_width} > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : {4'd0, screen_width};
    heff = ({4'd0, screen_height} > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT)
                                                      : {4'd0, screen_height};
    wlim = signed'({6'd0, weff, 4'd0});
    hlim = signed'({6'd0, heff, 4'd0});
    bl = mnx[21] ? 22'sd0 : mnx;
    bt = mny[21] ? 22'sd0 : mny;
    br = (mxx > wlim) ? wlim : mxx;
    bb = (mxy > hlim) ? hlim : mxy;
    br15 = br + 22'sd15;
    bb15 = bb + 22'sd15;
    box_empty = (bl >= br) || (bt >= bb);
    zcull = z_out(vz0) && z_out(vz1) && z_out(vz2);
    cx0 = signed'(22'({px0, 4'b1000}));
    cy0 = signed'(22'({py0, 4'b1000}));
  end

  // Serial multiplier for setup products.
  logic [4:0] job, job_sel;
  logic [5:0] mbit;
  logic signed [63:0] acc, acc_next, mcand, mcand_ld;
  logic [47:0] mplier;
  logic signed [21:0] ma;
  logic signed [47:0] mb;
  logic mneg, mul_done;
  logic [47:0] area;
  logic signed [47:0] w0s, w1s, w2s;
  logic signed [63:0] nsum, nx, ny;

  assign job_sel  = (state == trdt_pkg::ST_BOX) ? 5'd0 : job + 5'd1;
  assign mul_done = (mbit == 6'(trdt_pkg::MUL_BITS - 1));

  always_comb begin
    ma = '0;
    mb = '0;
    mneg = 1'b0;
    case (job_sel)
      5'd0:  begin ma = ex2 - ex0; mb = 48'(ea2); end
      5'd1:  begin ma = ey2 - ey0; mb = 48'(eb2); mneg = 1'b1; end
      5'd2:  begin ma = cx0 - ex1; mb = 48'(ea0); end
      5'd3:  begin ma = cy0 - ey1; mb = 48'(eb0); mneg = 1'b1; end
      5'd4:  begin ma = cx0 - ex2; mb = 48'(ea1); end
      5'd5:  begin ma = cy0 - ey2; mb = 48'(eb1); mneg = 1'b1; end
      5'd6:  begin ma = cx0 - ex0; mb = 48'(ea2); end
      5'd7:  begin ma = cy0 - ey0; mb = 48'(eb2); mneg = 1'b1; end
      5'd8:  begin ma = 22'(vz0); mb = w0s; end
      5'd9:  begin ma = 22'(vz1); mb = w1s; end
      5'd10: begin ma = 22'(vz2); mb = w2s; end
      5'd11: begin ma = 22'(vz0); mb = 48'(ea0); end
      5'd12: begin ma = 22'(vz1); mb = 48'(ea1); end
      5'd13: begin ma = 22'(vz2); mb = 48'(ea2); end
      5'd14: begin ma = 22'(vz0); mb = 48'(eb0); end
      5'd15: begin ma = 22'(vz1); mb = 48'(eb1); end
      5'd16: begin ma = 22'(vz2); mb = 48'(eb2); end
      default: ;
    endcase
    mcand_ld = mneg ? -64'(ma) : 64'(ma);
    // The top multiplier bit carries negative weight.
    if (!mplier[0]) acc_next = acc;
    else if (mul_done) acc_next = acc - mcand;
    else acc_next = acc + mcand;
  end

  // Restoring divider for the start depth and the two depth steps.
  logic [1:0] djob, dsel;
  logic [5:0] dbit;
  logic [63:0] dq, dq_next;
  logic [47:0] drem, drem_next;
  logic [48:0] dt;
  logic dge, dneg, div_done;
  logic signed [63:0] dividend, qres;
  logic [47:0] rres;
  logic signed [63:0] q0, qx, qy;
  logic [47:0] r0, rx, ry;

  assign dsel     = (state == trdt_pkg::ST_MUL) ? trdt_pkg::DJ_START : djob + 2'd1;
  assign div_done = (dbit == 6'(trdt_pkg::DIV_BITS - 1));

  always_comb begin
    case (dsel)
      trdt_pkg::DJ_START: dividend = nsum;
      trdt_pkg::DJ_STEPX: dividend = nx <<< 4;
      trdt_pkg::DJ_STEPY: dividend = -(ny <<< 4);
      default:            dividend = '0;
    endcase
    dt = {drem, dq[63]};
    dge = (dt >= {1'b0, area});
    drem_next = dge ? 48'(dt - {1'b0, area}) : dt[47:0];
    dq_next = {dq[62:0], dge};
    // Floor division for negative dividends.
    if (!dneg) begin
      qres = signed'(dq_next);
      rres = drem_next;
    end else if (drem_next == 48'd0) begin
      qres = -signed'(dq_next);
      rres = 48'd0;
    end else begin
      qres = -signed'(dq_next) - 64'sd1;
      rres = area - drem_next;
    end
  end

  // Pixel walk: edge values and depth held as quotient and remainder.
  logic signed [47:0] w0, w1, w2, wr0, wr1, wr2, sx0, sx1, sx2, sy0, sy1, sy2;
  logic signed [63:0] q, qr, q_x, q_y;
  logic [47:0] rem, remr, rem_x, rem_y;
  logic [48:0] rsx, rsy;
  logic cxx, cyy;
  logic [AW-1:0] rowaddr;
  logic [XW-1:0] px_inc;
  logic [YW-1:0] py_inc;
  logic last_col, last_pix, in_tri, inrange;

  always_comb begin
    sx0 = 48'(ea0) <<< 4; sx1 = 48'(ea1) <<< 4; sx2 = 48'(ea2) <<< 4;
    sy0 = -(48'(eb0) <<< 4); sy1 = -(48'(eb1) <<< 4); sy2 = -(48'(eb2) <<< 4);
    rsx = {1'b0, rem} + {1'b0, rx};
    cxx = (rsx >= {1'b0, area});
    rem_x = cxx ? 48'(rsx - {1'b0, area}) : rsx[47:0];
    q_x = q + qx + 64'(cxx);
    rsy = {1'b0, remr} + {1'b0, ry};
    cyy = (rsy >= {1'b0, area});
    rem_y = cyy ? 48'(rsy - {1'b0, area}) : rsy[47:0];
    q_y = qr + qy + 64'(cyy);
    px_inc = px + XW'(1);
    py_inc = py + YW'(1);
    last_col = (px_inc == px1);
    last_pix = last_col && (py_inc == py1);
    in_tri = !w0[47] && !w1[47] && !w2[47];
    inrange = !q[63] && ((q < trdt_pkg::DEPTH_ONE) ||
                         ((q == trdt_pkg::DEPTH_ONE) && (rem == 48'd0)));
  end

  // Store RAM: depth in the low bits, id above.
  logic [DW-1:0] mem [STORE];
  logic [DW-1:0] mem_rdata, mem_wdata;
  logic [AW-1:0] mem_raddr, mem_waddr, clr_addr, p_addr;
  logic mem_we, p_valid, clr_report, clr_done, win;
  logic [trdt_pkg::DEPTH_W-1:0] p_z;
  logic [31:0] pa32, rid32;
  logic rd_inr;

  assign pa32     = 32'(pix_addr);
  assign rd_inr   = (pa32 < 32'(STORE));
  assign rid32    = 32'(mem_rdata[DW-1:trdt_pkg::DEPTH_W]);
  assign clr_done = (clr_addr == AW'(STORE - 1));
  assign win      = p_valid && (p_z < mem_rdata[trdt_pkg::DEPTH_W-1:0]);

  always_comb begin
    mem_raddr = (state == trdt_pkg::ST_READ) ? pa32[AW-1:0] : rowaddr + AW'(px);
    if (state == trdt_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = {{INDEX_BITS{1'b1}}, trdt_pkg::DEPTH_EMPTY};
    end else begin
      mem_we = win;
      mem_waddr = p_addr;
      mem_wdata = {tid, p_z};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) state <= trdt_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      trdt_pkg::ST_CLEAR:
        if (clr_done) state_next = clr_report ? trdt_pkg::ST_DONE : trdt_pkg::ST_IDLE;
      trdt_pkg::ST_IDLE:
        if (s_acc) begin
          case (s_tuser)
            trdt_pkg::MODE_CLEAR: state_next = trdt_pkg::ST_CLEAR;
            trdt_pkg::MODE_DRAW:  state_next = trdt_pkg::ST_BOX;
            trdt_pkg::MODE_READ:  state_next = trdt_pkg::ST_READ;
            default:              state_next = trdt_pkg::ST_DONE;
          endcase
        end
      trdt_pkg::ST_READ:  state_next = trdt_pkg::ST_RDATA;
      trdt_pkg::ST_RDATA: state_next = trdt_pkg::ST_DONE;
      trdt_pkg::ST_BOX:
        state_next = (zcull || box_empty) ? trdt_pkg::ST_DONE : trdt_pkg::ST_MUL;
      trdt_pkg::ST_MUL:
        if (mul_done) begin
          if (job == trdt_pkg::JOB_AREA && acc_next <= 64'sd0) state_next = trdt_pkg::ST_DONE;
          else if (job == trdt_pkg::JOB_NY) state_next = trdt_pkg::ST_DIV;
        end
      trdt_pkg::ST_DIV:
        if (div_done && djob == trdt_pkg::DJ_STEPY) state_next = trdt_pkg::ST_WALK;
      trdt_pkg::ST_WALK:
        if (last_pix) state_next = trdt_pkg::ST_DRAIN;
      trdt_pkg::ST_DRAIN: state_next = trdt_pkg::ST_DONE;
      trdt_pkg::ST_DONE:
        if (!m_tvalid || m_tready) state_next = trdt_pkg::ST_IDLE;
      default: state_next = trdt_pkg::ST_IDLE;
    endcase
  end

  // Result registers.
  logic [trdt_pkg::DEPTH_W-1:0] res_depth;
  logic [trdt_pkg::ID_W-1:0]    res_id;
  logic [trdt_pkg::COUNT_W-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clr_report <= 1'b0;
      p_valid    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == trdt_pkg::ST_CLEAR) clr_addr <= clr_done ? '0 : clr_addr + AW'(1);
      if (s_acc) clr_report <= 1'b1;
      p_valid <= (state == trdt_pkg::ST_WALK) && in_tri && inrange;
      if (state == trdt_pkg::ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      vx0 <= signed'(s_tdata[19:0]);    vy0 <= signed'(s_tdata[39:20]);
      vz0 <= signed'(s_tdata[57:40]);
      vx1 <= signed'(s_tdata[77:58]);   vy1 <= signed'(s_tdata[97:78]);
      vz1 <= signed'(s_tdata[115:98]);
      vx2 <= signed'(s_tdata[135:116]); vy2 <= signed'(s_tdata[155:136]);
      vz2 <= signed'(s_tdata[173:156]);
      tid <= tid32[INDEX_BITS-1:0];
      pix_addr <= s_tdata[203:190];
      res_depth <= '0;
      res_id <= '0;
      res_count <= '0;
    end

    if (state == trdt_pkg::ST_RDATA) begin
      res_depth <= rd_inr ? mem_rdata[trdt_pkg::DEPTH_W-1:0] : trdt_pkg::DEPTH_EMPTY;
      res_id    <= rd_inr ? rid32[15:0] : 16'hFFFF;
    end

    if (win) res_count <= res_count + trdt_pkg::COUNT_W'(1);
    p_addr <= mem_raddr;
    p_z    <= q[trdt_pkg::DEPTH_W-1:0];

    if (state == trdt_pkg::ST_BOX) begin
      px0 <= bl[XW+3:4];
      px1 <= br15[XW+3:4];
      py0 <= bt[YW+3:4];
      py1 <= bb15[YW+3:4];
      job <= 5'd0;
      mbit <= '0;
      acc <= '0;
      mcand <= mcand_ld;
      mplier <= mb;
    end

    if (state == trdt_pkg::ST_MUL) begin
      if (mul_done) begin
        job <= job + 5'd1;
        mbit <= '0;
        mcand <= mcand_ld;
        mplier <= mb;
        case (job)
          trdt_pkg::JOB_AREA: area <= acc_next[47:0];
          trdt_pkg::JOB_W0:   w0s <= acc_next[47:0];
          trdt_pkg::JOB_W1:   w1s <= acc_next[47:0];
          trdt_pkg::JOB_W2:   w2s <= acc_next[47:0];
          trdt_pkg::JOB_NUM:  nsum <= acc_next;
          trdt_pkg::JOB_NX:   nx <= acc_next;
          trdt_pkg::JOB_NY:   ny <= acc_next;
          default: ;
        endcase
        if (job == trdt_pkg::JOB_AREA || job == trdt_pkg::JOB_W0 || job == trdt_pkg::JOB_W1 ||
            job == trdt_pkg::JOB_W2 || job == trdt_pkg::JOB_NUM || job == trdt_pkg::JOB_NX ||
            job == trdt_pkg::JOB_NY) acc <= '0;
        else acc <= acc_next;
        if (job == trdt_pkg::JOB_NY) begin
          djob <= trdt_pkg::DJ_START;
          dbit <= '0;
          drem <= '0;
          dneg <= dividend[63];
          dq <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        end
      end else begin
        acc <= acc_next;
        mbit <= mbit + 6'd1;
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
      end
    end

    if (state == trdt_pkg::ST_DIV) begin
      if (div_done) begin
        case (djob)
          trdt_pkg::DJ_START: begin q0 <= qres; r0 <= rres; end
          trdt_pkg::DJ_STEPX: begin qx <= qres; rx <= rres; end
          trdt_pkg::DJ_STEPY: begin qy <= qres; ry <= rres; end
          default: ;
        endcase
        djob <= djob + 2'd1;
        dbit <= '0;
        drem <= '0;
        dneg <= dividend[63];
        dq <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        if (djob == trdt_pkg::DJ_STEPY) begin
          w0 <= w0s; w1 <= w1s; w2 <= w2s;
          wr0 <= w0s; wr1 <= w1s; wr2 <= w2s;
          q <= q0; qr <= q0;
          rem <= r0; remr <= r0;
          px <= px0;
          py <= py0;
          rowaddr <= AW'(py0 * MAX_WIDTH);
        end
      end else begin
        dbit <= dbit + 6'd1;
        drem <= drem_next;
        dq <= dq_next;
      end
    end

    if (state == trdt_pkg::ST_WALK) begin
      if (last_col) begin
        px <= px0;
        py <= py_inc;
        rowaddr <= rowaddr + AW'(MAX_WIDTH);
        w0 <= wr0 + sy0; w1 <= wr1 + sy1; w2 <= wr2 + sy2;
        wr0 <= wr0 + sy0; wr1 <= wr1 + sy1; wr2 <= wr2 + sy2;
        q <= q_y; qr <= q_y;
        rem <= rem_y; remr <= rem_y;
      end else begin
        px <= px_inc;
        w0 <= w0 + sx0; w1 <= w1 + sx1; w2 <= w2 + sx2;
        q <= q_x;
        rem <= rem_x;
      end
    end

    if (state == trdt_pkg::ST_DONE && (!m_tvalid || m_tready))
      m_tdata <= {res_count, res_id, res_depth};
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for triangle_raster_depth_test: random and directed
// clear, draw and read beats checked against a depth/id store predictor.
// Depends on design/trdt_pkg.sv and design/triangle_raster_depth_test.sv.

module testbench;

  // The reserved fourth mode does nothing and returns an all-zero beat.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int STORE_WORDS = 16384;

  typedef struct {
    logic [1:0]         mode;
    logic signed [19:0] vx [3];
    logic signed [19:0] vy [3];
    logic signed [17:0] vz [3];
    logic [15:0]        tri_id;
    logic [13:0]        addr;
  } tri_item_t;

  typedef struct {
    logic [16:0] depth;
    logic [15:0] tri_id;
    logic [14:0] count;
  } pixel_result_t;

  class depth_scoreboard;
    logic [16:0]   depth_mem [STORE_WORDS];
    logic [15:0]   id_mem [STORE_WORDS];
    int unsigned   width_reg;
    int unsigned   height_reg;
    pixel_result_t expected_q [$];
    int            errors;
    int            results_seen;
    int            draws_seen;
    int            pixels_written;

    function new();
      width_reg = 128;
      height_reg = 128;
      wipe();
    endfunction

    function void wipe();
      foreach (depth_mem[i]) begin
        depth_mem[i] = trdt_pkg::DEPTH_EMPTY;
        id_mem[i] = '1;
      end
    endfunction

    function longint edge_val(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
      return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    endfunction

    function bit z_out(longint z);
      return z < 0 || z > 65536;
    endfunction

    function int unsigned raster(tri_item_t t);
      longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
      longint area, w_lim, h_lim, l, r, tp, bt, px, py, cx, cy, w0, w1, w2, num;
      int unsigned n;
      int a;
      n = 0;
      x0 = t.vx[0]; y0 = t.vy[0]; z0 = t.vz[0];
      x1 = t.vx[1]; y1 = t.vy[1]; z1 = t.vz[1];
      x2 = t.vx[2]; y2 = t.vy[2]; z2 = t.vz[2];
      area = edge_val(x0, y0, x1, y1, x2, y2);
      if (area <= 0) return 0;
      if (z_out(z0) && z_out(z1) && z_out(z2)) return 0;
      w_lim = width_reg > 128 ? 128 : width_reg;
      h_lim = height_reg > 128 ? 128 : height_reg;
      l = x0 < x1 ? x0 : x1; l = l < x2 ? l : x2; if (l < 0) l = 0;
      tp = y0 < y1 ? y0 : y1; tp = tp < y2 ? tp : y2; if (tp < 0) tp = 0;
      r = x0 > x1 ? x0 : x1; r = r > x2 ? r : x2; if (r > w_lim * 16) r = w_lim * 16;
      bt = y0 > y1 ? y0 : y1; bt = bt > y2 ? bt : y2;
      if (bt > h_lim * 16) bt = h_lim * 16;
      if (l >= r || tp >= bt) return 0;
      for (py = tp / 16; py < (bt + 15) / 16; py++) begin
        cy = py * 16 + 8;
        for (px = l / 16; px < (r + 15) / 16; px++) begin
          cx = px * 16 + 8;
          w0 = edge_val(x1, y1, x2, y2, cx, cy);
          w1 = edge_val(x2, y2, x0, y0, cx, cy);
          w2 = edge_val(x0, y0, x1, y1, cx, cy);
          if (w0 >= 0 && w1 >= 0 && w2 >= 0) begin
            num = w0 * z0 + w1 * z1 + w2 * z2;
            if (num >= 0 && num <= area * 65536) begin
              a = int'(py * 128 + px);
              if (a < STORE_WORDS && (num / area) < longint'(depth_mem[a])) begin
                depth_mem[a] = 17'(num / area);
                id_mem[a] = t.tri_id;
                n++;
              end
            end
          end
        end
      end
      return n;
    endfunction

    function void note_input(tri_item_t t);
      pixel_result_t res;
      res = '{depth: '0, tri_id: '0, count: '0};
      case (t.mode)
        trdt_pkg::MODE_CLEAR: wipe();
        trdt_pkg::MODE_DRAW: begin
          res.count = 15'(raster(t));
          draws_seen++;
          pixels_written += res.count;
        end
        trdt_pkg::MODE_READ: begin
          res.depth = depth_mem[t.addr];
          res.tri_id = id_mem[t.addr];
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [trdt_pkg::OUT_DATA_W-1:0] beat);
      pixel_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output beat %h", beat);
        return;
      end
      exp_res = expected_q.pop_front();
      if (beat[16:0] !== exp_res.depth || beat[32:17] !== exp_res.tri_id ||
          beat[47:33] !== exp_res.count) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch on beat %0d: depth %0d/%0d id %0d/%0d count %0d/%0d",
                   results_seen, exp_res.depth, beat[16:0], exp_res.tri_id,
                   beat[32:17], exp_res.count, beat[47:33]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [trdt_pkg::IN_DATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic [trdt_pkg::OUT_DATA_W-1:0] m_tdata;

  depth_scoreboard sb;
  bit no_gaps;
  bit stim_done;
  int holdoff_left;
  int sent_items;

  triangle_raster_depth_test uut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
  end

  // Output side: random back-pressure plus one long hold-off once the
  // result stream is under way, which fills the block and stalls its input.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        if (sb.results_seen == 40) holdoff_left = 3000;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_gaps || ($urandom_range(99) >= 20);
      end
    end
  end

  function automatic logic [trdt_pkg::IN_DATA_W-1:0] pack_item(tri_item_t t);
    return {4'b0, t.addr, t.tri_id,
            t.vz[2], t.vy[2], t.vx[2], t.vz[1], t.vy[1], t.vx[1],
            t.vz[0], t.vy[0], t.vx[0]};
  endfunction

  // Holds tvalid across back-to-back beats; it only drops before a gap or in drain.
  task automatic send_item(tri_item_t t);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 20) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_item(t);
    s_tuser <= t.mode;
    do @(posedge clk); while (!s_tready);
    sb.note_input(t);
    sent_items++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == trdt_pkg::REG_SCREEN_WIDTH) sb.width_reg = value[7:0];
    else sb.height_reg = value[7:0];
  endtask

  function automatic tri_item_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                         int za, int zb, int zc, int id);
    tri_item_t t;
    t.mode = trdt_pkg::MODE_DRAW;
    t.vx[0] = 20'(ax); t.vy[0] = 20'(ay); t.vz[0] = 18'(za);
    t.vx[1] = 20'(bx); t.vy[1] = 20'(by); t.vz[1] = 18'(zb);
    t.vx[2] = 20'(cx); t.vy[2] = 20'(cy); t.vz[2] = 18'(zc);
    t.tri_id = 16'(id);
    t.addr = 14'($urandom);
    return t;
  endfunction

  function automatic tri_item_t make_op(logic [1:0] mode, int addr);
    tri_item_t t;
    t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
    t.mode = mode;
    t.addr = 14'(addr);
    return t;
  endfunction

  function automatic tri_item_t random_item();
    tri_item_t t;
    int pick, bx, by, tmp;
    pick = $urandom_range(99);
    if (pick < 3) return make_op(trdt_pkg::MODE_CLEAR, $urandom);
    if (pick < 40) begin
      // Reads mostly land where the small triangles are drawn.
      if ($urandom_range(3) == 0) return make_op(trdt_pkg::MODE_READ, $urandom_range(16383));
      return make_op(trdt_pkg::MODE_READ, $urandom_range(48) * 128 + $urandom_range(70));
    end
    if (pick < 44) begin
      // Full-range vertices: bit coverage and whole-screen boxes.
      t = make_op(trdt_pkg::MODE_DRAW, $urandom);
    end else begin
      bx = $urandom_range(1100) - 100;
      by = $urandom_range(700) - 100;
      t = make_tri(bx, by, bx + $urandom_range(20), by + $urandom_range(60, 340),
                   bx + $urandom_range(60, 340), by + $urandom_range(20),
                   $urandom_range(80000) - 8000, $urandom_range(80000) - 8000,
                   $urandom_range(80000) - 8000, $urandom_range(65535));
    end
    // Some triangles wound the other way, which must be culled.
    if ($urandom_range(99) < 15) begin
      tmp = t.vx[1]; t.vx[1] = t.vx[2]; t.vx[2] = 20'(tmp);
      tmp = t.vy[1]; t.vy[1] = t.vy[2]; t.vy[2] = 20'(tmp);
    end
    return t;
  endfunction

  initial begin
    int phase;
    sb = new();
    no_gaps = 0;
    stim_done = 0;
    holdoff_left = 0;
    sent_items = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Wait out the clearing sweep that follows reset.
    do @(posedge clk); while (!s_tready);

    // Directed part.
    send_item(make_op(trdt_pkg::MODE_READ, 0));
    send_item(make_tri(0, 0, 0, 160, 160, 0, 0, 32768, 65536, 5));
    send_item(make_op(trdt_pkg::MODE_READ, 2 * 128 + 2));
    send_item(make_tri(0, 0, 0, 160, 160, 0, 40000, 40000, 40000, 6));
    send_item(make_tri(0, 0, 0, 160, 160, 0, 100, 100, 100, 65535));
    send_item(make_op(trdt_pkg::MODE_READ, 2 * 128 + 2));
    send_item(make_tri(0, 0, 160, 0, 0, 160, 1000, 1000, 1000, 7));
    send_item(make_tri(0, 0, 80, 80, 160, 160, 1000, 1000, 1000, 8));
    send_item(make_tri(32, 32, 32, 300, 300, 32, -131072, 131071, 70000, 9));
    send_item(make_tri(200, 200, 200, 500, 500, 200, 65536, 65536, 65536, 10));
    send_item(make_op(trdt_pkg::MODE_READ, 13 * 128 + 13));
    send_item(make_tri(-524288, -524288, -524288, 524287, 524287, -524288,
                       -131072, 131071, 32768, 16'hA5A5));
    send_item(make_op(trdt_pkg::MODE_READ, 16383));
    send_item(make_op(MODE_NONE, 0));
    send_item(make_op(trdt_pkg::MODE_READ, 127));
    send_item(make_op(trdt_pkg::MODE_CLEAR, 0));
    send_item(make_op(trdt_pkg::MODE_READ, 2 * 128 + 2));
    drain();

    // Random part, one screen setting per phase, including the extremes.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(trdt_pkg::REG_SCREEN_WIDTH, 1);
          write_reg(trdt_pkg::REG_SCREEN_HEIGHT, 1);
        end
        1: begin
          write_reg(trdt_pkg::REG_SCREEN_WIDTH, 0);
          write_reg(trdt_pkg::REG_SCREEN_HEIGHT, 90);
        end
        2: begin
          write_reg(trdt_pkg::REG_SCREEN_WIDTH, 255);
          write_reg(trdt_pkg::REG_SCREEN_HEIGHT, 255);
        end
        3: begin
          write_reg(trdt_pkg::REG_SCREEN_WIDTH, $urandom_range(2, 127));
          write_reg(trdt_pkg::REG_SCREEN_HEIGHT, $urandom_range(2, 127));
        end
        default: begin
          write_reg(trdt_pkg::REG_SCREEN_WIDTH, 128);
          write_reg(trdt_pkg::REG_SCREEN_HEIGHT, 128);
        end
      endcase
      no_gaps = (phase == 4);
      repeat (phase == 0 ? 12 : 24) send_item(random_item());
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Sent %0d beats (%0d draws writing %0d pixels), checked %0d results.",
             sent_items, sb.draws_seen, sb.pixels_written, sb.results_seen);
    $display("Screen settings covered zero, one, oversized, random and full size.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding.", sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
